[rtl/core/ica_pkg.sv]
// ----------------------------------------------------------------------------
// ica_pkg
// Opcodes, status codes and the command/status bundles shared by the
// calculator controller and datapath.
// ----------------------------------------------------------------------------
package ica_pkg;

  // Request opcodes
  localparam logic [3:0] OP_ADD  = 4'd0;
  localparam logic [3:0] OP_SUB  = 4'd1;
  localparam logic [3:0] OP_MUL  = 4'd2;
  localparam logic [3:0] OP_DIV  = 4'd3;
  localparam logic [3:0] OP_MOD  = 4'd4;
  localparam logic [3:0] OP_POW  = 4'd5;
  localparam logic [3:0] OP_FACT = 4'd6;
  localparam logic [3:0] OP_GCD  = 4'd7;
  localparam logic [3:0] OP_LCM  = 4'd8;

  // Result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_UNKNOWN  = 3'd1;
  localparam logic [2:0] ST_DIVZERO  = 3'd2;
  localparam logic [2:0] ST_DOMAIN   = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;

  // Operand pair loaded into the serial unit (low word, divisor/multiplicand)
  typedef enum logic [2:0] {
    SEL_XY, SEL_ACCX, SEL_XX, SEL_ACCY, SEL_ABS, SEL_AX, SEL_QB
  } sel_e;

  // Working register updates
  typedef enum logic [2:0] {
    WB_NONE, WB_ACC, WB_SQ, WB_FACT, WB_GCD, WB_TWO
  } wb_e;

  // Result source
  typedef enum logic [2:0] {
    RES_ZERO, RES_ADD, RES_SUB, RES_PROD, RES_QUO, RES_REM, RES_ACC, RES_X
  } res_e;

  typedef struct packed {
    logic       load;
    logic       start;
    logic       div;
    sel_e       sel;
    wb_e        wb;
    logic       fin;
    res_e       res;
    logic [2:0] status;
  } cmd_t;

  typedef struct packed {
    logic a_neg;
    logic b_neg;
    logic a_zero;
    logic b_zero;
    logic b_ones;
    logic a_min;
    logic y_zero;
    logic y_lsb;
    logic acc_zero;
    logic y_gt_a;
    logic busy;
    logic prod_ovf;
  } sts_t;

endpackage

[rtl/core/ica_dpath.sv]
// ----------------------------------------------------------------------------
// ica_dpath
// Operand and working registers, a shared bit-serial multiply/divide unit
// and the result register.
// ----------------------------------------------------------------------------
module ica_dpath #(
  parameter int DATA_WIDTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ica_pkg::cmd_t cmd_i,
  output ica_pkg::sts_t sts_o,
  input  logic [31:0]   operand_a_i,
  input  logic [31:0]   operand_b_i,
  output logic [31:0]   result_value_o,
  output logic [2:0]    status_o
);
  import ica_pkg::*;

  localparam int W    = DATA_WIDTH;
  localparam int CNTW = $clog2(W);

  logic [W-1:0] a_q, b_q, x_q, y_q, acc_q;
  logic [W-1:0] hi_q, lo_q, dv_q;
  logic [CNTW-1:0] cnt_q;
  logic busy_q, div_q;
  logic [W-1:0] res_q;
  logic [2:0]   st_q;

  logic [W-1:0] a_in, b_in, abs_a, abs_b, lo_init, dv_init, res_d;
  logic [W:0]   mul_sum, div_sh, div_diff;

  // Operands narrowed or sign-extended to the working width
  assign a_in  = W'($signed(operand_a_i));
  assign b_in  = W'($signed(operand_b_i));
  assign abs_a = a_q[W-1] ? (~a_q + W'(1)) : a_q;
  assign abs_b = b_q[W-1] ? (~b_q + W'(1)) : b_q;

  // Serial step: shift-add multiply, restoring divide
  assign mul_sum  = {1'b0, hi_q} + (lo_q[0] ? {1'b0, dv_q} : '0);
  assign div_sh   = {hi_q, lo_q[W-1]};
  assign div_diff = div_sh - {1'b0, dv_q};

  // Unit operand select
  always_comb begin
    unique case (cmd_i.sel)
      SEL_XY:   begin lo_init = x_q;   dv_init = y_q;   end
      SEL_ACCX: begin lo_init = acc_q; dv_init = x_q;   end
      SEL_XX:   begin lo_init = x_q;   dv_init = x_q;   end
      SEL_ACCY: begin lo_init = acc_q; dv_init = y_q;   end
      SEL_ABS:  begin lo_init = abs_a; dv_init = abs_b; end
      SEL_AX:   begin lo_init = a_q;   dv_init = x_q;   end
      SEL_QB:   begin lo_init = lo_q;  dv_init = b_q;   end
      default:  begin lo_init = x_q;   dv_init = y_q;   end
    endcase
  end

  // Unit control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      div_q  <= 1'b0;
    end else if (cmd_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
      div_q  <= cmd_i.div;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CNTW'(1);
      if (cnt_q == CNTW'(W - 1)) busy_q <= 1'b0;
    end
  end

  // Unit data
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      hi_q <= '0;
      lo_q <= lo_init;
      dv_q <= dv_init;
    end else if (busy_q) begin
      if (div_q) begin
        hi_q <= div_diff[W] ? div_sh[W-1:0] : div_diff[W-1:0];
        lo_q <= {lo_q[W-2:0], ~div_diff[W]};
      end else begin
        hi_q <= mul_sum[W:1];
        lo_q <= {mul_sum[0], lo_q[W-1:1]};
      end
    end
  end

  // Operand and working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      a_q   <= a_in;
      b_q   <= b_in;
      x_q   <= a_in;
      y_q   <= b_in;
      acc_q <= W'(1);
    end else begin
      unique case (cmd_i.wb)
        WB_ACC:  acc_q <= lo_q;
        WB_SQ:   begin x_q <= lo_q; y_q <= y_q >> 1; end
        WB_FACT: begin acc_q <= lo_q; y_q <= y_q + W'(1); end
        WB_GCD:  begin x_q <= y_q; y_q <= hi_q; end
        WB_TWO:  y_q <= W'(2);
        default: ;
      endcase
    end
  end

  // Result select
  always_comb begin
    unique case (cmd_i.res)
      RES_ADD:  res_d = a_q + b_q;
      RES_SUB:  res_d = a_q - b_q;
      RES_PROD: res_d = lo_q;
      RES_QUO:  res_d = (a_q[W-1] ^ b_q[W-1]) ? (~lo_q + W'(1)) : lo_q;
      RES_REM:  res_d = a_q[W-1] ? (~hi_q + W'(1)) : hi_q;
      RES_ACC:  res_d = acc_q;
      RES_X:    res_d = x_q;
      default:  res_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      res_q <= res_d;
      st_q  <= cmd_i.status;
    end
  end

  assign result_value_o = 32'($signed(res_q));
  assign status_o       = st_q;

  // Flags for the controller
  assign sts_o.a_neg    = a_q[W-1];
  assign sts_o.b_neg    = b_q[W-1];
  assign sts_o.a_zero   = (a_q == '0);
  assign sts_o.b_zero   = (b_q == '0);
  assign sts_o.b_ones   = &b_q;
  assign sts_o.a_min    = (a_q == {1'b1, {(W-1){1'b0}}});
  assign sts_o.y_zero   = (y_q == '0);
  assign sts_o.y_lsb    = y_q[0];
  assign sts_o.acc_zero = (acc_q == '0);
  assign sts_o.y_gt_a   = (y_q > a_q);
  assign sts_o.busy     = busy_q;
  assign sts_o.prod_ovf = (hi_q != '0) || lo_q[W-1];

endmodule

[rtl/core/ica_ctrl.sv]
// ----------------------------------------------------------------------------
// ica_ctrl
// Sequencer: decodes the opcode, checks special cases and steps the
// datapath through the power, factorial and Euclid loops.
// ----------------------------------------------------------------------------
module ica_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [3:0]    req_type_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ica_pkg::cmd_t cmd_o,
  input  ica_pkg::sts_t sts_i
);
  import ica_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DEC      = 4'd1;
  localparam logic [3:0] S_MUL_W    = 4'd2;
  localparam logic [3:0] S_DIV_W    = 4'd3;
  localparam logic [3:0] S_POW_CHK  = 4'd4;
  localparam logic [3:0] S_POW_MA   = 4'd5;
  localparam logic [3:0] S_POW_SQ   = 4'd6;
  localparam logic [3:0] S_FACT_CHK = 4'd7;
  localparam logic [3:0] S_FACT_W   = 4'd8;
  localparam logic [3:0] S_GCD_CHK  = 4'd9;
  localparam logic [3:0] S_GCD_W    = 4'd10;
  localparam logic [3:0] S_LCM_DIV  = 4'd11;
  localparam logic [3:0] S_LCM_MUL  = 4'd12;
  localparam logic [3:0] S_DONE     = 4'd13;

  logic [3:0] state_q, state_d;
  logic [3:0] op_q;
  logic       accept;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_DONE);
  assign accept      = in_valid_i && in_ready_o;

  // Next state and datapath commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.sel  = SEL_XY;
    cmd_o.wb   = WB_NONE;
    cmd_o.res  = RES_ZERO;
    cmd_o.status = ST_OK;
    cmd_o.load = accept;
    unique case (state_q)
      S_IDLE: if (accept) state_d = S_DEC;
      S_DEC: begin
        state_d   = S_DONE;
        cmd_o.fin = 1'b1;
        unique case (op_q)
          OP_ADD: cmd_o.res = RES_ADD;
          OP_SUB: cmd_o.res = RES_SUB;
          OP_MUL: begin
            cmd_o.fin   = 1'b0;
            cmd_o.start = 1'b1;
            state_d     = S_MUL_W;
          end
          OP_DIV, OP_MOD: begin
            if (sts_i.b_zero) begin
              cmd_o.status = ST_DIVZERO;
            end else if (op_q == OP_DIV && sts_i.a_min && sts_i.b_ones) begin
              cmd_o.status = ST_OVERFLOW;
            end else begin
              cmd_o.fin   = 1'b0;
              cmd_o.start = 1'b1;
              cmd_o.div   = 1'b1;
              cmd_o.sel   = SEL_ABS;
              state_d     = S_DIV_W;
            end
          end
          OP_POW: begin
            if (sts_i.b_neg) cmd_o.status = ST_DOMAIN;
            else begin
              cmd_o.fin = 1'b0;
              state_d   = S_POW_CHK;
            end
          end
          OP_FACT: begin
            if (sts_i.a_neg) cmd_o.status = ST_DOMAIN;
            else begin
              cmd_o.fin = 1'b0;
              cmd_o.wb  = WB_TWO;
              state_d   = S_FACT_CHK;
            end
          end
          OP_GCD, OP_LCM: begin
            if (sts_i.a_neg || sts_i.b_neg || sts_i.a_zero || sts_i.b_zero) begin
              cmd_o.status = ST_DOMAIN;
            end else begin
              cmd_o.fin = 1'b0;
              state_d   = S_GCD_CHK;
            end
          end
          default: cmd_o.status = ST_UNKNOWN;
        endcase
      end
      S_MUL_W: if (!sts_i.busy) begin
        cmd_o.fin = 1'b1;
        cmd_o.res = RES_PROD;
        state_d   = S_DONE;
      end
      S_DIV_W: if (!sts_i.busy) begin
        cmd_o.fin = 1'b1;
        cmd_o.res = (op_q == OP_DIV) ? RES_QUO : RES_REM;
        state_d   = S_DONE;
      end
      // Square-and-multiply, exponent bit by bit from the bottom
      S_POW_CHK: begin
        if (sts_i.y_zero) begin
          cmd_o.fin = 1'b1;
          cmd_o.res = RES_ACC;
          state_d   = S_DONE;
        end else begin
          cmd_o.start = 1'b1;
          cmd_o.sel   = sts_i.y_lsb ? SEL_ACCX : SEL_XX;
          state_d     = sts_i.y_lsb ? S_POW_MA : S_POW_SQ;
        end
      end
      S_POW_MA: if (!sts_i.busy) begin
        cmd_o.wb    = WB_ACC;
        cmd_o.start = 1'b1;
        cmd_o.sel   = SEL_XX;
        state_d     = S_POW_SQ;
      end
      S_POW_SQ: if (!sts_i.busy) begin
        cmd_o.wb = WB_SQ;
        state_d  = S_POW_CHK;
      end
      // Running product, stops early once it wraps to zero
      S_FACT_CHK: begin
        if (sts_i.y_gt_a || sts_i.acc_zero) begin
          cmd_o.fin = 1'b1;
          cmd_o.res = RES_ACC;
          state_d   = S_DONE;
        end else begin
          cmd_o.start = 1'b1;
          cmd_o.sel   = SEL_ACCY;
          state_d     = S_FACT_W;
        end
      end
      S_FACT_W: if (!sts_i.busy) begin
        cmd_o.wb = WB_FACT;
        state_d  = S_FACT_CHK;
      end
      // Euclid by remainders
      S_GCD_CHK: begin
        if (!sts_i.y_zero) begin
          cmd_o.start = 1'b1;
          cmd_o.div   = 1'b1;
          cmd_o.sel   = SEL_XY;
          state_d     = S_GCD_W;
        end else if (op_q == OP_LCM) begin
          cmd_o.start = 1'b1;
          cmd_o.div   = 1'b1;
          cmd_o.sel   = SEL_AX;
          state_d     = S_LCM_DIV;
        end else begin
          cmd_o.fin = 1'b1;
          cmd_o.res = RES_X;
          state_d   = S_DONE;
        end
      end
      S_GCD_W: if (!sts_i.busy) begin
        cmd_o.wb = WB_GCD;
        state_d  = S_GCD_CHK;
      end
      S_LCM_DIV: if (!sts_i.busy) begin
        cmd_o.start = 1'b1;
        cmd_o.sel   = SEL_QB;
        state_d     = S_LCM_MUL;
      end
      S_LCM_MUL: if (!sts_i.busy) begin
        cmd_o.fin = 1'b1;
        if (sts_i.prod_ovf) cmd_o.status = ST_OVERFLOW;
        else cmd_o.res = RES_PROD;
        state_d = S_DONE;
      end
      S_DONE: if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) op_q <= req_type_i;
  end

  // Checks
  a_ready_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready and valid together");

  a_start_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start |-> !sts_i.busy) else $error("unit started while busy");

  a_fin_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.fin |=> out_valid_o) else $error("result not presented");

  a_accept_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_DEC)) else $error("accept did not decode");

endmodule

[rtl/core/integer_calculator_alu.sv]
// ----------------------------------------------------------------------------
// integer_calculator_alu
// Integer calculator: add, sub, mul, div, mod, power, factorial, gcd, lcm
// with a status code per result.
// ----------------------------------------------------------------------------
//  channel | handshake                 | word
//  --------+---------------------------+-------------------------------------
//  in      | in_valid_i / in_ready_o   | req_type_i, operand_a_i, operand_b_i
//  out     | out_valid_o / out_ready_i | result_value_o, status_o
//
//  One word at a time. Add and sub go from idle through decode to the done
//  state; mul, div and mod wait on the shared multiply/divide unit, which
//  works one bit per cycle. Power, factorial and gcd/lcm loop on that unit,
//  once per multiply or remainder step.
//  Reset clears the sequencer and the unit's busy flag and step count; the
//  data registers are not reset. in_ready_o is high only when idle.
//  A held result stalls the block until out_ready_i takes it.
// ----------------------------------------------------------------------------
module integer_calculator_alu #(
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  req_type_i,
  input  logic [31:0] operand_a_i,
  input  logic [31:0] operand_b_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] result_value_o,
  output logic [2:0]  status_o
);
  import ica_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ica_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  ica_dpath #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .operand_a_i    (operand_a_i),
    .operand_b_i    (operand_b_i),
    .result_value_o (result_value_o),
    .status_o       (status_o)
  );

endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for integer_calculator_alu. Requests are sent over the
// valid/ready input channel with random gaps. Results come back under random
// receiver stalls. Each result is checked against a behavioural calculator
// that works out value and status for every accepted request.
// ----------------------------------------------------------------------------
module tb;
  import ica_pkg::*;

  typedef struct {
    logic [3:0]  op;
    logic [31:0] a;
    logic [31:0] b;
  } calc_req_t;

  typedef struct {
    logic [31:0] value;
    logic [2:0]  status;
  } calc_res_t;

  localparam logic [31:0] MOST_NEG = 32'h8000_0000;
  localparam logic [31:0] MOST_POS = 32'h7fff_ffff;
  localparam logic [31:0] ALL_ONES = 32'hffff_ffff;

  // Euclid on positive operands
  function automatic logic [31:0] gcd_of(logic [31:0] x, logic [31:0] y);
    logic [31:0] r;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    return x;
  endfunction

  // Behavioural calculator: value and status for one request
  function automatic calc_res_t calc_result(calc_req_t rq);
    calc_res_t   rs;
    logic [31:0] base, acc, q;
    logic [31:0] ex;
    longint      i;
    rs.value  = '0;
    rs.status = ST_OK;
    case (rq.op)
      OP_ADD: rs.value = rq.a + rq.b;
      OP_SUB: rs.value = rq.a - rq.b;
      OP_MUL: rs.value = rq.a * rq.b;
      OP_DIV: begin
        if (rq.b == 0) rs.status = ST_DIVZERO;
        else if (rq.a == MOST_NEG && rq.b == ALL_ONES) rs.status = ST_OVERFLOW;
        else rs.value = $signed(rq.a) / $signed(rq.b);
      end
      OP_MOD: begin
        if (rq.b == 0) rs.status = ST_DIVZERO;
        else if (rq.b == ALL_ONES) rs.value = '0;
        else rs.value = $signed(rq.a) % $signed(rq.b);
      end
      OP_POW: begin
        if (rq.b[31]) rs.status = ST_DOMAIN;
        else begin
          base = rq.a;
          ex   = rq.b;
          acc  = 32'd1;
          while (ex != 0) begin
            if (ex[0]) acc = acc * base;
            base = base * base;
            ex   = ex >> 1;
          end
          rs.value = acc;
        end
      end
      OP_FACT: begin
        if (rq.a[31]) rs.status = ST_DOMAIN;
        else begin
          acc = 32'd1;
          // product gains a factor of two often enough to wrap to zero early
          for (i = 2; i <= longint'(rq.a) && acc != 0; i++) acc = acc * i[31:0];
          rs.value = acc;
        end
      end
      OP_GCD, OP_LCM: begin
        if (rq.a[31] || rq.b[31] || rq.a == 0 || rq.b == 0) rs.status = ST_DOMAIN;
        else if (rq.op == OP_GCD) rs.value = gcd_of(rq.a, rq.b);
        else begin
          q = rq.a / gcd_of(rq.a, rq.b);
          if (q > MOST_POS / rq.b) rs.status = ST_OVERFLOW;
          else rs.value = q * rq.b;
        end
      end
      default: rs.status = ST_UNKNOWN;
    endcase
    if (rs.status != ST_OK) rs.value = '0;
    return rs;
  endfunction

  // Expected results in request order
  class calc_scoreboard;
    calc_res_t pending[$];
    int        mismatches;

    function void note_request(calc_req_t rq);
      pending.push_back(calc_result(rq));
    endfunction

    function void check_result(logic [31:0] value, logic [2:0] status);
      calc_res_t exp_res;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h status %0d", value, status);
        return;
      end
      exp_res = pending.pop_front();
      if (value !== exp_res.value || status !== exp_res.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: value %h status %0d, expected value %h status %0d",
                   value, status, exp_res.value, exp_res.status);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [3:0]  req_type_i = '0;
  logic [31:0] operand_a_i = '0;
  logic [31:0] operand_b_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] result_value_o;
  logic [2:0]  status_o;

  calc_scoreboard sb = new();
  calc_req_t      requests[$];
  int             results_taken = 0;

  integer_calculator_alu dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Operand with a bias towards the interesting corners
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0:       return MOST_NEG;
      1:       return MOST_POS;
      2:       return ALL_ONES;
      3:       return 32'd0;
      4, 5, 6: return $urandom_range(0, 40) - 8;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_req(logic [3:0] op, logic [31:0] a, logic [31:0] b);
    calc_req_t rq;
    rq.op = op;
    rq.a  = a;
    rq.b  = b;
    requests.push_back(rq);
  endtask

  task automatic build_requests();
    calc_req_t rq;
    // directed: extremes and every special case
    add_req(OP_ADD, MOST_POS, 32'd1);
    add_req(OP_ADD, ALL_ONES, ALL_ONES);
    add_req(OP_SUB, MOST_NEG, 32'd1);
    add_req(OP_SUB, 32'd0, MOST_NEG);
    add_req(OP_MUL, MOST_POS, MOST_POS);
    add_req(OP_MUL, MOST_NEG, ALL_ONES);
    add_req(OP_DIV, 32'd7, 32'd0);
    add_req(OP_DIV, MOST_NEG, ALL_ONES);
    add_req(OP_DIV, -32'sd7, 32'd2);
    add_req(OP_MOD, 32'd7, 32'd0);
    add_req(OP_MOD, MOST_NEG, ALL_ONES);
    add_req(OP_MOD, -32'sd7, 32'd3);
    add_req(OP_POW, 32'd3, ALL_ONES);
    add_req(OP_POW, MOST_NEG, 32'd0);
    add_req(OP_POW, 32'd3, MOST_POS);
    add_req(OP_FACT, ALL_ONES, 32'd0);
    add_req(OP_FACT, 32'd0, 32'd5);
    add_req(OP_FACT, 32'd12, ALL_ONES);
    add_req(OP_FACT, MOST_POS, 32'd0);
    add_req(OP_GCD, 32'd0, 32'd5);
    add_req(OP_GCD, 32'd48, ALL_ONES);
    add_req(OP_GCD, MOST_POS, 32'd1836311903);
    add_req(OP_LCM, 32'd6, 32'd4);
    add_req(OP_LCM, MOST_POS, 32'd2);
    add_req(4'd9, 32'd1, 32'd1);
    add_req(4'd15, ALL_ONES, ALL_ONES);
    // random: mostly valid opcodes, some unknown ones
    repeat (750) begin
      rq.op = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                          : 4'($urandom_range(0, 8));
      rq.a  = pick_operand();
      rq.b  = pick_operand();
      if (rq.op == OP_FACT && $urandom_range(0, 3) != 0) rq.a = $urandom_range(0, 40);
      if ((rq.op == OP_GCD || rq.op == OP_LCM) && $urandom_range(0, 3) != 0) begin
        rq.a = $urandom_range(1, 32'h7fff_ffff);
        rq.b = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 5000) : rq.a / 3 + 1;
      end
      requests.push_back(rq);
    end
  endtask

  // Sender: random gap per word, valid held across back-to-back words
  task automatic send_requests();
    int gap;
    foreach (requests[n]) begin
      gap = (n > 40 && n < 80) ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_valid_i  <= 1'b1;
      req_type_i  <= requests[n].op;
      operand_a_i <= requests[n].a;
      operand_b_i <= requests[n].b;
      @(posedge clk_i);
      while (!in_ready_o) @(posedge clk_i);
      sb.note_request(requests[n]);
    end
    in_valid_i <= 1'b0;
  endtask

  // Receiver: random stall per word, one long hold-off early on
  task automatic take_results();
    int stall;
    forever begin
      stall = (results_taken == 30) ? 400 :
              (results_taken > 100 && results_taken < 140) ? 0 : $urandom_range(0, 5);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      sb.check_result(result_value_o, status_o);
      results_taken++;
    end
  endtask

  initial begin
    build_requests();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    fork
      take_results();
    join_none
    send_requests();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("PASS integer_calculator_alu");
    end else begin
      $display("FAIL integer_calculator_alu");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #40_000_000;
    $display("FAIL integer_calculator_alu");
    $finish;
  end

endmodule

[integer_calculator_alu.f]
rtl/core/ica_pkg.sv
rtl/core/ica_dpath.sv
rtl/core/ica_ctrl.sv
rtl/core/integer_calculator_alu.sv
sim/tb.sv
